### src/assert_macros.svh
// Assertion helpers for the RTL; included by pixel_undistort_backproject.
// Every macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PUD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pud: assertion failed");

// Next-cycle implication.
`define PUD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pud: assertion failed");

`endif

### src/pud_pkg.sv
// Package for the pixel back-projection block: types, codes, saturation helpers
// and the sequencer's microprogram. No dependencies.
`default_nettype none

package pud_pkg;

	localparam int MAX_ITERATIONS_DEF = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic signed [63:0] LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

	localparam int DIV_STEPS = 96;
	localparam int DIV_CNT_W = 7;

	localparam int PC_W = 6;
	localparam logic [PC_W-1:0] LOOP_PC  = 6'd4;
	localparam logic [PC_W-1:0] DIST2_PC = 6'd29;
	localparam logic [PC_W-1:0] EPI_PC   = 6'd60;
	localparam logic [PC_W-1:0] OUT_PC   = 6'd62;
	localparam logic [PC_W-1:0] DIST_LAST = 6'd20;

	typedef enum logic [2:0] {
		CFG_FOCAL, CFG_PP, CFG_K1, CFG_K2, CFG_K3, CFG_P1, CFG_P2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_BRZ, OP_OUT
	} op_t;

	typedef enum logic [1:0] {SH_0, SH_28, SH_32} sh_t;

	// 0..15 are register-file entries, 16 and up are constants and inputs
	typedef enum logic [4:0] {
		R_XD, R_YD, R_X, R_Y, R_T1, R_T2, R_R2, R_G,
		R_RF, R_A1, R_A2, R_A3, R_T3, R_T4, R_DX, R_DY,
		S_ZERO, S_ONE, S_K1S, S_K2S, S_K3, S_P1, S_P2, S_UC,
		S_VC, S_FX, S_FY, S_Z
	} src_t;

	typedef struct packed {
		op_t  op;
		src_t dst;
		src_t a;
		src_t b;
		sh_t  sh;
	} instr_t;

	typedef enum logic [1:0] {SEQ_IDLE, SEQ_FETCH, SEQ_EXEC, SEQ_WAIT} seq_state_t;

	typedef enum logic [2:0] {
		AR_IDLE, AR_MUL, AR_MFIN, AR_DIV, AR_DFIN, AR_DONE
	} ar_state_t;

	typedef struct packed {
		logic start;
		logic is_div;
		sh_t  sh;
	} arith_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] value;
	} arith_rsp_t;

	function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
		logic signed [63:0] r;
		if (v > LIM)
			r = LIM;
		else if (v < -LIM)
			r = -LIM;
		else
			r = $signed(v[63:0]);
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic instr_t mk(input op_t op, input src_t dst, input src_t a,
			input src_t b, input sh_t sh);
		instr_t i;
		i.op = op;
		i.dst = dst;
		i.a = a;
		i.b = b;
		i.sh = sh;
		return i;
	endfunction

	// Re-distortion of (x, y): r2, radial factor (Horner), dx, dy
	function automatic instr_t dist_instr(input logic [PC_W-1:0] k);
		instr_t i;
		unique case (k)
			6'd0:  i = mk(OP_MUL, R_T1, R_X,   R_X,  SH_32);
			6'd1:  i = mk(OP_MUL, R_T2, R_Y,   R_Y,  SH_32);
			6'd2:  i = mk(OP_ADD, R_R2, R_T1,  R_T2, SH_0);
			6'd3:  i = mk(OP_MUL, R_G,  S_K3,  R_R2, SH_28);
			6'd4:  i = mk(OP_ADD, R_G,  R_G,   S_K2S, SH_0);
			6'd5:  i = mk(OP_MUL, R_G,  R_G,   R_R2, SH_32);
			6'd6:  i = mk(OP_ADD, R_G,  R_G,   S_K1S, SH_0);
			6'd7:  i = mk(OP_MUL, R_G,  R_G,   R_R2, SH_32);
			6'd8:  i = mk(OP_ADD, R_RF, S_ONE, R_G,  SH_0);
			6'd9:  i = mk(OP_MUL, R_A1, R_X,   R_Y,  SH_32);
			6'd10: i = mk(OP_ADD, R_A1, R_A1,  R_A1, SH_0);
			6'd11: i = mk(OP_ADD, R_T3, R_T1,  R_T1, SH_0);
			6'd12: i = mk(OP_ADD, R_A2, R_R2,  R_T3, SH_0);
			6'd13: i = mk(OP_ADD, R_T3, R_T2,  R_T2, SH_0);
			6'd14: i = mk(OP_ADD, R_A3, R_R2,  R_T3, SH_0);
			6'd15: i = mk(OP_MUL, R_T3, S_P1,  R_A1, SH_28);
			6'd16: i = mk(OP_MUL, R_T4, S_P2,  R_A2, SH_28);
			6'd17: i = mk(OP_ADD, R_DX, R_T3,  R_T4, SH_0);
			6'd18: i = mk(OP_MUL, R_T3, S_P1,  R_A3, SH_28);
			6'd19: i = mk(OP_MUL, R_T4, S_P2,  R_A1, SH_28);
			6'd20: i = mk(OP_ADD, R_DY, R_T3,  R_T4, SH_0);
			default: i = mk(OP_ADD, R_T3, S_ZERO, S_ZERO, SH_0);
		endcase
		return i;
	endfunction

	function automatic instr_t prog_at(input logic [PC_W-1:0] pc);
		instr_t i;
		if (pc >= LOOP_PC && pc <= LOOP_PC + DIST_LAST)
			i = dist_instr(pc - LOOP_PC);
		else if (pc >= DIST2_PC && pc <= DIST2_PC + DIST_LAST)
			i = dist_instr(pc - DIST2_PC);
		else begin
			unique case (pc)
				6'd0:  i = mk(OP_DIV, R_XD, S_UC, S_FX,   SH_0);
				6'd1:  i = mk(OP_DIV, R_YD, S_VC, S_FY,   SH_0);
				6'd2:  i = mk(OP_ADD, R_X,  R_XD, S_ZERO, SH_0);
				6'd3:  i = mk(OP_ADD, R_Y,  R_YD, S_ZERO, SH_0);
				6'd25: i = mk(OP_SUB, R_T3, R_XD, R_DX,   SH_0);
				6'd26: i = mk(OP_DIV, R_X,  R_T3, R_RF,   SH_0);
				6'd27: i = mk(OP_SUB, R_T3, R_YD, R_DY,   SH_0);
				6'd28: i = mk(OP_DIV, R_Y,  R_T3, R_RF,   SH_0);
				6'd50: i = mk(OP_MUL, R_T3, R_RF, R_X,    SH_32);
				6'd51: i = mk(OP_ADD, R_T3, R_T3, R_DX,   SH_0);
				6'd52: i = mk(OP_SUB, R_T3, R_XD, R_T3,   SH_0);
				6'd53: i = mk(OP_MUL, R_A1, R_T3, R_T3,   SH_0);
				6'd54: i = mk(OP_MUL, R_T3, R_RF, R_Y,    SH_32);
				6'd55: i = mk(OP_ADD, R_T3, R_T3, R_DY,   SH_0);
				6'd56: i = mk(OP_SUB, R_T3, R_YD, R_T3,   SH_0);
				6'd57: i = mk(OP_MUL, R_T4, R_T3, R_T3,   SH_0);
				6'd58: i = mk(OP_ADD, R_T3, R_A1, R_T4,   SH_0);
				6'd59: i = mk(OP_BRZ, R_T3, R_T3, R_T3,   SH_0);
				6'd60: i = mk(OP_MUL, R_T3, R_X,  S_Z,    SH_32);
				6'd61: i = mk(OP_MUL, R_T4, R_Y,  S_Z,    SH_32);
				default: i = mk(OP_OUT, R_T3, R_T3, R_T4, SH_0);
			endcase
		end
		return i;
	endfunction

endpackage

`default_nettype wire

### src/pud_if.sv
// Valid/ready channels of the pixel back-projection block.
// Uses no package.
`default_nettype none

interface pud_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pixel_u;
	logic signed [31:0] pixel_v;
	logic signed [31:0] depth;
	modport source(output valid, output pixel_u, output pixel_v, output depth, input ready);
	modport sink(input valid, input pixel_u, input pixel_v, input depth, output ready);
endinterface

interface pud_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cam_x;
	logic signed [31:0] cam_y;
	logic signed [31:0] cam_z;
	modport source(output valid, output cam_x, output cam_y, output cam_z, input ready);
	modport sink(input valid, input cam_x, input cam_y, input cam_z, output ready);
endinterface

`default_nettype wire

### src/pud_arith.sv
// Shared multi-cycle multiply (four 32x32 partial products) and restoring
// divider (one quotient bit a cycle). Depends on pud_pkg.
`default_nettype none

module pud_arith (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pud_pkg::arith_req_t req,
	input  wire logic signed [63:0]  a,
	input  wire logic signed [63:0]  b,
	output pud_pkg::arith_rsp_t      rsp
);

	pud_pkg::ar_state_t state_q, state_d;

	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	pud_pkg::sh_t sh_q;
	logic [1:0]   step_q;
	logic [127:0] acc_q;

	logic [63:0]  n_q, d_q, rem_q, quo_q;
	logic         over_q;
	logic [pud_pkg::DIV_CNT_W-1:0] cnt_q;

	logic signed [63:0] res_q;

	logic [63:0]  n_start, d_start;
	logic [31:0]  a_half, b_half;
	logic [63:0]  partial;
	logic [127:0] partial_sh;
	logic [127:0] shifted;
	logic [63:0]  mul_mag;
	logic [63:0]  rem_sh, rem_n, quo_n;
	logic         over_n;
	logic [63:0]  div_mag;

	assign n_start = pud_pkg::mag64(pud_pkg::sat64({a[63], a}));
	assign d_start = pud_pkg::mag64(pud_pkg::sat64({b[63], b}));

	// partial products: al*bl, al*bh, ah*bl, ah*bh
	assign a_half  = step_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign b_half  = step_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign partial = a_half * b_half;

	always_comb begin
		unique case (step_q)
			2'd0:       partial_sh = {64'd0, partial};
			2'd1, 2'd2: partial_sh = {32'd0, partial, 32'd0};
			default:    partial_sh = {partial, 64'd0};
		endcase
	end

	always_comb begin
		unique case (sh_q)
			pud_pkg::SH_28: shifted = acc_q >> 28;
			pud_pkg::SH_32: shifted = acc_q >> 32;
			default:        shifted = acc_q;
		endcase
		mul_mag = (shifted > {64'd0, pud_pkg::LIM}) ? pud_pkg::LIM : shifted[63:0];
	end

	always_comb begin
		rem_sh = {rem_q[62:0], n_q[63]};
		over_n = over_q | (quo_q > (pud_pkg::LIM >> 1));
		if (rem_sh >= d_q) begin
			rem_n = rem_sh - d_q;
			quo_n = {quo_q[62:0], 1'b1};
		end else begin
			rem_n = rem_sh;
			quo_n = {quo_q[62:0], 1'b0};
		end
		div_mag = (over_q || quo_q > pud_pkg::LIM) ? pud_pkg::LIM : quo_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pud_pkg::AR_IDLE: begin
				if (req.start) begin
					if (!req.is_div)
						state_d = pud_pkg::AR_MUL;
					else if (n_start == 64'd0 || d_start == 64'd0)
						state_d = pud_pkg::AR_DONE;
					else
						state_d = pud_pkg::AR_DIV;
				end
			end
			pud_pkg::AR_MUL:  if (step_q == 2'd3) state_d = pud_pkg::AR_MFIN;
			pud_pkg::AR_MFIN: state_d = pud_pkg::AR_DONE;
			pud_pkg::AR_DIV: begin
				if (cnt_q == pud_pkg::DIV_CNT_W'(pud_pkg::DIV_STEPS - 1))
					state_d = pud_pkg::AR_DFIN;
			end
			pud_pkg::AR_DFIN: state_d = pud_pkg::AR_DONE;
			default:          state_d = pud_pkg::AR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pud_pkg::AR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pud_pkg::AR_IDLE: begin
				neg_q  <= a[63] ^ b[63];
				sh_q   <= req.sh;
				step_q <= 2'd0;
				cnt_q  <= '0;
				ma_q   <= pud_pkg::mag64(a);
				mb_q   <= pud_pkg::mag64(b);
				n_q    <= n_start;
				d_q    <= d_start;
				rem_q  <= '0;
				quo_q  <= '0;
				over_q <= 1'b0;
				acc_q  <= '0;
				// degenerate quotients finish at once
				if (n_start == 64'd0)
					res_q <= '0;
				else
					res_q <= a[63] ? -pud_pkg::LIM : pud_pkg::LIM;
			end
			pud_pkg::AR_MUL: begin
				acc_q  <= acc_q + partial_sh;
				step_q <= step_q + 2'd1;
			end
			pud_pkg::AR_MFIN: res_q <= neg_q ? -$signed(mul_mag) : $signed(mul_mag);
			pud_pkg::AR_DIV: begin
				n_q    <= {n_q[62:0], 1'b0};
				rem_q  <= rem_n;
				quo_q  <= quo_n;
				over_q <= over_n;
				cnt_q  <= cnt_q + 1'b1;
			end
			pud_pkg::AR_DFIN: res_q <= neg_q ? -$signed(div_mag) : $signed(div_mag);
			default: ;
		endcase
	end

	assign rsp.done  = (state_q == pud_pkg::AR_DONE);
	assign rsp.value = res_q;

endmodule

`default_nettype wire

### src/pixel_undistort_backproject.sv
// Passes: N = 1..MAX_ITERATIONS per request; each pass runs on the shared divider
//   (two quotients per pass) and the 4-step multiplier (24 products per pass).
// Throughput: one request at a time; input ready only while the sequencer is idle.
// Reset: arst_n clears the sequencer and loads fx = fy = 1.0, all other configuration 0.
// Depends on pud_pkg, pud_if, pud_arith and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module pixel_undistort_backproject #(
	parameter int MAX_ITERATIONS = pud_pkg::MAX_ITERATIONS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	pud_in_if.sink                              in_ch,
	pud_out_if.source                           out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [pud_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pud_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IT_W = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(MAX_ITERATIONS - 1);

	// configuration
	logic [63:0]        focal_q, pp_q;
	logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;

	// sequencer
	pud_pkg::seq_state_t      state_q, state_d;
	logic [pud_pkg::PC_W-1:0] pc_q, pc_d;
	logic [IT_W-1:0]          it_q, it_d;
	pud_pkg::instr_t          ins;

	// request capture and working registers
	logic signed [31:0] u_q, v_q, z_q;
	logic signed [63:0] regs_q [16];
	logic signed [63:0] opa_q, opb_q;
	logic signed [63:0] cval [16];
	logic signed [63:0] opa_sat, opb_sat;

	logic               wr_en;
	logic signed [63:0] wr_data;
	logic               out_load;
	logic               in_acc;

	logic               out_valid_q;
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;

	pud_pkg::arith_req_t req;
	pud_pkg::arith_rsp_t rsp;

	function automatic logic signed [31:0] to_out(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = $signed(v[31:0]);
		return r;
	endfunction

	assign ins    = pud_pkg::prog_at(pc_q);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == pud_pkg::SEQ_IDLE);

	// operands clamped before the saturating add
	assign opa_sat = pud_pkg::sat64({opa_q[63], opa_q});
	assign opb_sat = pud_pkg::sat64({opb_q[63], opb_q});

	// constant and input operands; index is the source code minus 16
	always_comb begin
		for (int i = 0; i < 16; i++)
			cval[i] = '0;
		cval[1]  = pud_pkg::ONE_Q32;
		cval[2]  = {{28{k1_q[31]}}, k1_q, 4'b0};      // Q28 -> Q32
		cval[3]  = {{28{k2_q[31]}}, k2_q, 4'b0};
		cval[4]  = {{32{k3_q[31]}}, k3_q};
		cval[5]  = {{32{p1_q[31]}}, p1_q};
		cval[6]  = {{32{p2_q[31]}}, p2_q};
		cval[7]  = {{32{u_q[31]}}, u_q} - {32'd0, pp_q[31:0]};
		cval[8]  = {{32{v_q[31]}}, v_q} - {32'd0, pp_q[63:32]};
		cval[9]  = {32'd0, focal_q[31:0]};
		cval[10] = {32'd0, focal_q[63:32]};
		cval[11] = {{32{z_q[31]}}, z_q};
	end

	// next state and controls
	always_comb begin
		state_d    = state_q;
		pc_d       = pc_q;
		it_d       = it_q;
		wr_en      = 1'b0;
		wr_data    = rsp.value;
		out_load   = 1'b0;
		req.start  = 1'b0;
		req.is_div = (ins.op == pud_pkg::OP_DIV);
		req.sh     = ins.sh;
		unique case (state_q)
			pud_pkg::SEQ_IDLE: begin
				if (in_ch.valid) begin
					state_d = pud_pkg::SEQ_FETCH;
					pc_d    = '0;
					it_d    = '0;
				end
			end
			pud_pkg::SEQ_FETCH: state_d = pud_pkg::SEQ_EXEC;
			pud_pkg::SEQ_EXEC: begin
				unique case (ins.op)
					pud_pkg::OP_ADD, pud_pkg::OP_SUB: begin
						// saturating add or subtract: both operands clamped, then the sum or difference
						wr_en = 1'b1;
						if (ins.op == pud_pkg::OP_SUB)
							wr_data = pud_pkg::sat64({opa_sat[63], opa_sat} -
								{opb_sat[63], opb_sat});
						else
							wr_data = pud_pkg::sat64({opa_sat[63], opa_sat} +
								{opb_sat[63], opb_sat});
						pc_d    = pc_q + 1'b1;
						state_d = pud_pkg::SEQ_FETCH;
					end
					pud_pkg::OP_MUL, pud_pkg::OP_DIV: begin
						req.start = 1'b1;
						state_d   = pud_pkg::SEQ_WAIT;
					end
					pud_pkg::OP_BRZ: begin
						// converged (squared error zero) or out of passes
						if (opa_q == 64'sd0 || it_q == IT_LAST) begin
							pc_d = pud_pkg::EPI_PC;
						end else begin
							pc_d = pud_pkg::LOOP_PC;
							it_d = it_q + 1'b1;
						end
						state_d = pud_pkg::SEQ_FETCH;
					end
					pud_pkg::OP_OUT: begin
						// result register must be free or draining this cycle
						if (!out_valid_q || out_ch.ready) begin
							out_load = 1'b1;
							state_d  = pud_pkg::SEQ_IDLE;
						end
					end
					default: state_d = pud_pkg::SEQ_IDLE;
				endcase
			end
			pud_pkg::SEQ_WAIT: begin
				if (rsp.done) begin
					wr_en   = 1'b1;
					pc_d    = pc_q + 1'b1;
					state_d = pud_pkg::SEQ_FETCH;
				end
			end
			default: state_d = pud_pkg::SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pud_pkg::SEQ_IDLE;
			pc_q        <= '0;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			it_q    <= it_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= 64'h0001_0000_0001_0000;
			pp_q    <= '0;
			k1_q    <= '0;
			k2_q    <= '0;
			k3_q    <= '0;
			p1_q    <= '0;
			p2_q    <= '0;
		end else if (cfg_we) begin
			unique case (pud_pkg::cfg_idx_t'(cfg_index))
				pud_pkg::CFG_FOCAL: focal_q <= cfg_wdata;
				pud_pkg::CFG_PP:    pp_q    <= cfg_wdata;
				pud_pkg::CFG_K1:    k1_q    <= $signed(cfg_wdata[31:0]);
				pud_pkg::CFG_K2:    k2_q    <= $signed(cfg_wdata[31:0]);
				pud_pkg::CFG_K3:    k3_q    <= $signed(cfg_wdata[31:0]);
				pud_pkg::CFG_P1:    p1_q    <= $signed(cfg_wdata[31:0]);
				pud_pkg::CFG_P2:    p2_q    <= $signed(cfg_wdata[31:0]);
				default: ;
			endcase
		end
	end

	// payload: request capture, register file, operand fetch, result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			u_q <= in_ch.pixel_u;
			v_q <= in_ch.pixel_v;
			z_q <= in_ch.depth;
		end
		if (state_q == pud_pkg::SEQ_FETCH) begin
			opa_q <= ins.a[4] ? cval[ins.a[3:0]] : regs_q[ins.a[3:0]];
			opb_q <= ins.b[4] ? cval[ins.b[3:0]] : regs_q[ins.b[3:0]];
		end
		if (wr_en)
			regs_q[ins.dst[3:0]] <= wr_data;
		if (out_load) begin
			cam_x_q <= to_out(opa_q);
			cam_y_q <= to_out(opb_q);
			cam_z_q <= z_q;
		end
	end

	pud_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (opa_q),
		.b      (opb_q),
		.rsp    (rsp)
	);

	assign out_ch.valid = out_valid_q;
	assign out_ch.cam_x = cam_x_q;
	assign out_ch.cam_y = cam_y_q;
	assign out_ch.cam_z = cam_z_q;

	`PUD_ASSERT_NEXT(a_start_pc, in_ch.valid && in_ch.ready, state_q == pud_pkg::SEQ_FETCH && pc_q == '0)
	`PUD_ASSERT_IMP(a_done_in_wait, rsp.done, state_q == pud_pkg::SEQ_WAIT)
	`PUD_ASSERT_IMP(a_out_pc, out_load, pc_q == pud_pkg::OUT_PC)

endmodule

`default_nettype wire

### dv/pud_backproject_checker.sv
// Checker for the pixel back-projection block: mirrors the config port, predicts camera points
// per accepted request and compares them with the output channel. Depends on pud_pkg, pud_if.
`timescale 1ns / 1ps

module pud_backproject_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	pud_in_if                                   in_ch,
	pud_out_if                                  out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [pud_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pud_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  checked
);

	typedef logic signed [63:0] q_t;
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cam_pt_t;

	cam_pt_t expected_pts[$];

	logic [63:0] focal, ppoint;
	q_t k1, k2, k3, p1, p2;

	function automatic q_t sat_q(input logic signed [64:0] v);
		if (v > pud_pkg::LIM)
			return pud_pkg::LIM;
		if (v < -pud_pkg::LIM)
			return -pud_pkg::LIM;
		return v[63:0];
	endfunction

	function automatic q_t add_q(input q_t a, input q_t b);
		logic signed [64:0] s;
		s = sat_q(a);
		s = s + sat_q(b);
		return sat_q(s);
	endfunction

	function automatic logic [63:0] abs_q(input q_t a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	// magnitude product, shifted down, clamped, sign restored
	function automatic q_t mul_q(input q_t a, input q_t b, input int sh);
		logic [127:0] p;
		logic [127:0] r;
		p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
		r = p >> sh;
		if (r > 128'(pud_pkg::LIM))
			r = 128'(pud_pkg::LIM);
		return (a[63] != b[63]) ? -q_t'(r[63:0]) : q_t'(r[63:0]);
	endfunction

	function automatic q_t div_q(input q_t num, input q_t den);
		logic [63:0] n, d;
		logic [127:0] q;
		n = abs_q(sat_q(num));
		d = abs_q(sat_q(den));
		if (n == 0)
			return 0;
		if (d == 0)
			return num[63] ? -pud_pkg::LIM : pud_pkg::LIM;
		q = {32'd0, n, 32'd0} / {64'd0, d};
		if (q > 128'(pud_pkg::LIM))
			q = 128'(pud_pkg::LIM);
		return (num[63] != den[63]) ? -q_t'(q[63:0]) : q_t'(q[63:0]);
	endfunction

	// 1 + k1 r2 + k2 r4 + k3 r6, Horner form
	function automatic q_t radial_gain(input q_t r2);
		q_t g;
		g = add_q(mul_q(k3, r2, 28), k2 <<< 4);
		g = add_q(mul_q(g, r2, 32), k1 <<< 4);
		g = mul_q(g, r2, 32);
		return add_q(pud_pkg::ONE_Q32, g);
	endfunction

	function automatic void tangential_shift(input q_t x, input q_t y, input q_t r2,
			output q_t dx, output q_t dy);
		q_t xy2, ax, ay;
		xy2 = mul_q(x, y, 32);
		xy2 = add_q(xy2, xy2);
		ax = add_q(r2, add_q(mul_q(x, x, 32), mul_q(x, x, 32)));
		ay = add_q(r2, add_q(mul_q(y, y, 32), mul_q(y, y, 32)));
		dx = add_q(mul_q(p1, xy2, 28), mul_q(p2, ax, 28));
		dy = add_q(mul_q(p1, ay, 28), mul_q(p2, xy2, 28));
	endfunction

	function automatic logic signed [31:0] clamp32(input q_t v);
		if (v > 64'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic cam_pt_t backproject(input logic signed [31:0] u,
			input logic signed [31:0] v, input logic signed [31:0] z);
		q_t xd, yd, x, y, r2, rf, dx, dy, ex, ey, e2, zq;
		cam_pt_t pt;
		xd = div_q(q_t'(u) - q_t'({32'd0, ppoint[31:0]}), q_t'({32'd0, focal[31:0]}));
		yd = div_q(q_t'(v) - q_t'({32'd0, ppoint[63:32]}), q_t'({32'd0, focal[63:32]}));
		x = xd;
		y = yd;
		zq = z;
		for (int it = 0; it < pud_pkg::MAX_ITERATIONS_DEF; it++) begin
			r2 = add_q(mul_q(x, x, 32), mul_q(y, y, 32));
			rf = radial_gain(r2);
			tangential_shift(x, y, r2, dx, dy);
			x = div_q(add_q(xd, -dx), rf);
			y = div_q(add_q(yd, -dy), rf);
			// re-distort and test for an exact fit at Q64
			r2 = add_q(mul_q(x, x, 32), mul_q(y, y, 32));
			rf = radial_gain(r2);
			tangential_shift(x, y, r2, dx, dy);
			ex = add_q(xd, -add_q(mul_q(rf, x, 32), dx));
			ey = add_q(yd, -add_q(mul_q(rf, y, 32), dy));
			e2 = add_q(mul_q(ex, ex, 0), mul_q(ey, ey, 0));
			if (e2 <= 0)
				break;
		end
		pt.x = clamp32(mul_q(x, zq, 32));
		pt.y = clamp32(mul_q(y, zq, 32));
		pt.z = z;
		return pt;
	endfunction

	assign pending = expected_pts.size();

	always @(posedge clk or negedge arst_n) begin
		cam_pt_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			focal <= 64'h0001_0000_0001_0000;
			ppoint <= '0;
			k1 <= 0; k2 <= 0; k3 <= 0; p1 <= 0; p2 <= 0;
			mismatches <= 0;
			checked <= 0;
			expected_pts.delete();
		end else begin
			if (cfg_we) begin
				case (pud_pkg::cfg_idx_t'(cfg_index))
					pud_pkg::CFG_FOCAL: focal <= cfg_wdata;
					pud_pkg::CFG_PP:    ppoint <= cfg_wdata;
					pud_pkg::CFG_K1:    k1 <= $signed(cfg_wdata[31:0]);
					pud_pkg::CFG_K2:    k2 <= $signed(cfg_wdata[31:0]);
					pud_pkg::CFG_K3:    k3 <= $signed(cfg_wdata[31:0]);
					pud_pkg::CFG_P1:    p1 <= $signed(cfg_wdata[31:0]);
					pud_pkg::CFG_P2:    p2 <= $signed(cfg_wdata[31:0]);
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				expected_pts.push_back(backproject(in_ch.pixel_u, in_ch.pixel_v, in_ch.depth));
			if (out_ch.valid && out_ch.ready) begin
				checked <= checked + 1;
				if (expected_pts.size() == 0) begin
					$error("unexpected result x=%0d y=%0d z=%0d",
						out_ch.cam_x, out_ch.cam_y, out_ch.cam_z);
					errs++;
				end else begin
					want = expected_pts.pop_front();
					if (out_ch.cam_x !== want.x) begin
						$error("cam_x: expected %0d, got %0d", want.x, out_ch.cam_x);
						errs++;
					end
					if (out_ch.cam_y !== want.y) begin
						$error("cam_y: expected %0d, got %0d", want.y, out_ch.cam_y);
						errs++;
					end
					if (out_ch.cam_z !== want.z) begin
						$error("cam_z: expected %0d, got %0d", want.z, out_ch.cam_z);
						errs++;
					end
				end
				mismatches <= mismatches + errs;
			end
		end
	end

endmodule

### dv/tb_top.sv
// Top of the pixel back-projection testbench: clock, reset, stimulus and verdict.
// Depends on pud_pkg, pud_if, the block itself and pud_backproject_checker.
`timescale 1ns / 1ps

module tb_top;

	// The limit must cover the worst request and the long receiver hold.
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int LONG_HOLD      = 2500;
	localparam int RAND_PHASES    = 12;
	localparam int PER_PHASE      = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pud_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pud_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	pud_in_if  in_ch();
	pud_out_if out_ch();

	int mismatches, pending, checked;
	int sent = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;   // request for one long receiver stall
	bit busy_mode = 1'b0;  // no gaps on either side

	always #1 clk = ~clk;

	pixel_undistort_backproject DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	pud_backproject_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .pending(pending), .checked(checked)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (busy_mode || r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver: random back-pressure, plus one long hold when asked.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_off = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (busy_mode) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= (pick_gap() == 0);
			end
		end
	end

	// Watchdog: cycles with no request or result moving.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles, %0d results pending",
				idle_cycles, pending);
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic write_reg(input pud_pkg::cfg_idx_t idx, input logic [63:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_lens(input logic [63:0] f, input logic [63:0] pp,
			input logic [31:0] c1, input logic [31:0] c2, input logic [31:0] c3,
			input logic [31:0] t1, input logic [31:0] t2);
		write_reg(pud_pkg::CFG_FOCAL, f);
		write_reg(pud_pkg::CFG_PP, pp);
		write_reg(pud_pkg::CFG_K1, {32'd0, c1});
		write_reg(pud_pkg::CFG_K2, {32'd0, c2});
		write_reg(pud_pkg::CFG_K3, {32'd0, c3});
		write_reg(pud_pkg::CFG_P1, {32'd0, t1});
		write_reg(pud_pkg::CFG_P2, {32'd0, t2});
	endtask

	// Hold the sender until every predicted point has come back.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One request; valid stays high across back-to-back requests.
	task automatic send(input logic [31:0] u, input logic [31:0] v, input logic [31:0] z);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.pixel_u <= u;
		in_ch.pixel_v <= v;
		in_ch.depth <= z;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sent++;
	endtask

	// Coordinates near a 1280x960 sensor most of the time, raw bits otherwise.
	task automatic send_random();
		logic [31:0] u, v, z;
		if ($urandom_range(0, 99) < 15) begin
			u = $urandom;
			v = $urandom;
			z = $urandom;
		end else begin
			u = {16'($urandom_range(0, 1279)), 16'h0} | $urandom_range(0, 65535);
			v = {16'($urandom_range(0, 959)), 16'h0} | $urandom_range(0, 65535);
			z = $urandom_range(6554, 100 << 16);
			if ($urandom_range(0, 9) == 0)
				z = -z;
		end
		send(u, v, z);
	endtask

	// Small Q4.28 coefficient, magnitude up to lim.
	function automatic logic [31:0] coef(input int lim);
		int c;
		c = $urandom_range(0, lim);
		return ($urandom_range(0, 1) != 0) ? -c : c;
	endfunction

	task automatic random_lens(input int kind);
		logic [31:0] fx, fy;
		if (kind == 0) begin
			// raw register bits
			load_lens({$urandom, $urandom}, {$urandom, $urandom},
				$urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			fx = {16'($urandom_range(300, 1500)), 16'h0} | $urandom_range(0, 65535);
			fy = {16'($urandom_range(300, 1500)), 16'h0} | $urandom_range(0, 65535);
			if (kind == 1)
				load_lens({fy, fx}, {$urandom_range(400, 560) << 16, $urandom_range(560, 720) << 16},
					0, 0, 0, 0, 0);
			else
				load_lens({fy, fx}, {$urandom_range(400, 560) << 16, $urandom_range(560, 720) << 16},
					coef(80000000), coef(27000000), coef(2700000),
					coef(1300000), coef(1300000));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.pixel_u = '0;
		in_ch.pixel_v = '0;
		in_ch.depth = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset lens: identity projection, field extremes and output saturation.
		send(32'h0, 32'h0, 32'h0);
		send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
		send(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000);
		send(32'h1234_5678, 32'hEDCB_A987, 32'h7FFF_FFFF);
		drain();

		// Zero focal lengths: quotient saturates, or is zero for a zero numerator.
		load_lens(64'h0, 64'h0, 0, 0, 0, 0, 0);
		send(32'h0000_0005, 32'hFFFF_FFFB, 32'h0001_0000);
		send(32'h0, 32'h0, 32'h0001_0000);
		drain();

		// k1 = -1 with a normalized point at radius 1: radial factor collapses to zero.
		load_lens(64'h0001_0000_0001_0000, 64'h0, 32'hF000_0000, 0, 0, 0, 0);
		send(32'h0001_0000, 32'h0, 32'h0001_0000);
		send(32'h0, 32'hFFFF_0000, 32'h0002_0000);
		drain();

		// Register extremes.
		load_lens(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(32'h0, 32'h7FFF_FFFF, 32'h0001_0000);
		send(32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
		drain();
		load_lens(64'h0000_0001_0000_0001, 64'h0, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(32'h0000_0003, 32'hFFFF_FFFD, 32'h0001_0000);
		send(32'h0001_8000, 32'h0002_0000, 32'hFFFF_0000);
		drain();

		// Random part: lens changes between phases, one flavor per phase.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			random_lens((ph % 4 == 3) ? 0 : ((ph % 4 == 1) ? 1 : 2));
			busy_mode = (ph == 5);
			for (int i = 0; i < PER_PHASE; i++) begin
				// mid-phase long receiver stall while requests keep coming
				if (ph == 2 && i == 10)
					hold_off = 1'b1;
				send_random();
			end
			drain();
		end
		busy_mode = 1'b0;

		repeat (200) @(posedge clk);
		$display("run: %0d requests sent, %0d results compared", sent, checked);
		$display("lens: reset, zero focal, singular radial, register extremes, %0d random phases",
			RAND_PHASES);
		if (mismatches == 0 && pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/pud_pkg.sv
src/pud_if.sv
src/pud_arith.sv
src/pixel_undistort_backproject.sv
dv/pud_backproject_checker.sv
dv/tb_top.sv
